// ===== sv/wtsp_pkg.sv =====
package wtsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MATRIX_WORDS  = 16;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [11:0] WIDTH_RESET  = 12'd1024;
  localparam logic [11:0] HEIGHT_RESET = 12'd768;

endpackage

// ===== sv/world_to_screen_projection_top.sv =====
// A projection passes the capture, product, sum, divider, sign and scale registers to the result
// strobe (values Q16.16 by default); a load request gives no result and takes effect at its accepting edge.
// Throughput: one request per cycle; busy stays low and results cannot be stalled.
// The divider resolves one quotient bit per stage.
// Reset clears the matrix, the pipeline valid bits and restores the window size.
module world_to_screen_projection_top
  import wtsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [3:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data,
  output logic               result_valid,
  output logic               on_screen,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int SUM_W = 46;
  localparam logic signed [31:0] W_THRESH = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic               accept;
  logic signed [31:0] mat [0:MATRIX_WORDS-1];
  logic [11:0]        window_width;
  logic [11:0]        window_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  window_width  <= cfg_data;
        CFG_HEIGHT: window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_WORDS; i++) mat[i] <= '0;
    end else if (accept && op == OP_LOAD) begin
      mat[entry_index] <= entry_value;
    end
  end

  // Stage 1: capture the point.
  logic               v1;
  logic signed [31:0] p1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept && op == OP_PROJECT;
    p1[0] <= pos_x;
    p1[1] <= pos_y;
    p1[2] <= pos_z;
  end

  // Stage 2: nine products; rows 0, 1 and 3 of the matrix (x, y, w).
  logic               v2;
  logic signed [63:0] prod2 [0:2][0:2];
  logic signed [31:0] tr2 [0:2];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod2[r][c] <= p1[c] * mat[4 * c + (r == 2 ? 3 : r)];
      end
      tr2[r] <= mat[12 + (r == 2 ? 3 : r)];
    end
  end

  // Stage 3: floor shift, sum with translation and saturate.
  logic               v3;
  logic signed [31:0] clip3 [0:2];
  logic signed [65:0] csum [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      csum[r] = 66'(tr2[r]) + 66'(prod2[r][0] >>> FRAC_BITS)
              + 66'(prod2[r][1] >>> FRAC_BITS) + 66'(prod2[r][2] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int r = 0; r < 3; r++) begin
      if (csum[r] > 66'sh0_7FFF_FFFF)       clip3[r] <= 32'sh7FFF_FFFF;
      else if (csum[r] < -66'sh0_8000_0000) clip3[r] <= 32'sh8000_0000;
      else                                  clip3[r] <= csum[r][31:0];
    end
  end

  // Divider: stage 0 holds magnitudes, each later stage resolves one quotient bit.
  logic             dv   [0:NUM_W];
  logic             don  [0:NUM_W];
  logic             dngx [0:NUM_W];
  logic             dngy [0:NUM_W];
  logic [31:0]      dw   [0:NUM_W];
  logic [NUM_W-1:0] dnx  [0:NUM_W];
  logic [NUM_W-1:0] dny  [0:NUM_W];
  logic [31:0]      drx  [0:NUM_W];
  logic [31:0]      dry  [0:NUM_W];
  logic [NUM_W-1:0] dqx  [0:NUM_W];
  logic [NUM_W-1:0] dqy  [0:NUM_W];

  logic [31:0] magx, magy;
  logic        on3;

  assign magx = clip3[0][31] ? 32'(-clip3[0]) : 32'(clip3[0]);
  assign magy = clip3[1][31] ? 32'(-clip3[1]) : 32'(clip3[1]);
  assign on3  = clip3[2] >= W_THRESH;

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v3;
    don[0]  <= on3;
    dngx[0] <= clip3[0][31];
    dngy[0] <= clip3[1][31];
    dw[0]   <= on3 ? 32'(clip3[2]) : 32'd1;
    dnx[0]  <= {magx, FRAC_BITS'(0)};
    dny[0]  <= {magy, FRAC_BITS'(0)};
    drx[0]  <= '0;
    dry[0]  <= '0;
    dqx[0]  <= '0;
    dqy[0]  <= '0;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [32:0] shx, shy;
    logic        gex, gey;

    assign shx = {drx[k], dnx[k][NUM_W-1]};
    assign shy = {dry[k], dny[k][NUM_W-1]};
    assign gex = shx >= {1'b0, dw[k]};
    assign gey = shy >= {1'b0, dw[k]};

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
      don[k+1]  <= don[k];
      dngx[k+1] <= dngx[k];
      dngy[k+1] <= dngy[k];
      dw[k+1]   <= dw[k];
      dnx[k+1]  <= dnx[k] << 1;
      dny[k+1]  <= dny[k] << 1;
      drx[k+1]  <= gex ? 32'(shx - {1'b0, dw[k]}) : shx[31:0];
      dry[k+1]  <= gey ? 32'(shy - {1'b0, dw[k]}) : shy[31:0];
      dqx[k+1]  <= {dqx[k][NUM_W-2:0], gex};
      dqy[k+1]  <= {dqy[k][NUM_W-2:0], gey};
    end
  end

  // Sign and saturate the quotients to NDC.
  logic               v5, on5;
  logic signed [31:0] nx5, ny5;

  function automatic logic signed [31:0] sign_sat(input logic [NUM_W-1:0] q, input logic neg);
    logic signed [NUM_W:0] s;
    s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (s > $signed((NUM_W+1)'(32'h7FFF_FFFF)))      sign_sat = 32'sh7FFF_FFFF;
    else if (s < -$signed((NUM_W+1)'(33'h8000_0000))) sign_sat = 32'sh8000_0000;
    else                                              sign_sat = s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= dv[NUM_W];
    on5 <= don[NUM_W];
    nx5 <= sign_sat(dqx[NUM_W], dngx[NUM_W]);
    ny5 <= sign_sat(dqy[NUM_W], dngy[NUM_W]);
  end

  // Scale by the half window size.
  logic               v6, on6;
  logic signed [31:0] nx6, ny6;
  logic signed [43:0] px6, py6;
  logic [10:0]        hw, hh;

  assign hw = window_width[11:1];
  assign hh = window_height[11:1];

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    on6 <= on5;
    nx6 <= nx5;
    ny6 <= ny5;
    px6 <= $signed({1'b0, hw}) * nx5;
    py6 <= $signed({1'b0, hh}) * ny5;
  end

  logic signed [SUM_W-1:0] sx, sy, hwq, hhq;

  assign hwq = $signed(SUM_W'({hw, FRAC_BITS'(0)}));
  assign hhq = $signed(SUM_W'({hh, FRAC_BITS'(0)}));
  assign sx  = SUM_W'(px6) + SUM_W'(nx6) + hwq;
  assign sy  = -SUM_W'(py6) + SUM_W'(ny6) + hhq;

  function automatic logic signed [31:0] sat_sum(input logic signed [SUM_W-1:0] s);
    if (s > $signed(SUM_W'(32'h7FFF_FFFF)))       sat_sum = 32'sh7FFF_FFFF;
    else if (s < -$signed(SUM_W'(33'h8000_0000))) sat_sum = 32'sh8000_0000;
    else                                          sat_sum = s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= v6;
    on_screen <= on6;
    screen_x  <= on6 ? sat_sum(sx) : 32'sd0;
    screen_y  <= on6 ? sat_sum(sy) : 32'sd0;
  end

endmodule

// ===== verif/tb_world_to_screen_projection_top.sv =====
`timescale 1ns / 1ps

class projection_scoreboard;
  typedef struct {
    logic        vis;
    logic [31:0] sx;
    logic [31:0] sy;
  } screen_point_t;

  longint      matrix[16];
  int unsigned win_w;
  int unsigned win_h;
  screen_point_t pending_points[$];
  int errors;
  int projected;
  int offscreen;

  function void clear();
    foreach (matrix[i]) matrix[i] = 0;
    win_w = 1024;
    win_h = 768;
    pending_points.delete();
    errors = 0;
    projected = 0;
    offscreen = 0;
  endfunction

  function void set_window(logic idx, logic [11:0] val);
    if (idx == wtsp_pkg::CFG_WIDTH) win_w = 32'(val);
    else win_h = 32'(val);
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint clip_coord(longint p[3], int row);
    longint s;
    s = matrix[12 + row];
    // Arithmetic shift rounds each product toward minus infinity.
    for (int c = 0; c < 3; c++) s += (p[c] * matrix[4 * c + row]) >>> 16;
    return clamp32(s);
  endfunction

  function void note_request(logic op, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    longint p[3];
    longint cx, cy, cw, nx, ny, hw, hh;
    screen_point_t r;
    if (op == wtsp_pkg::OP_LOAD) begin
      matrix[idx] = longint'(val);
      return;
    end
    p[0] = longint'(x);
    p[1] = longint'(y);
    p[2] = longint'(z);
    cx = clip_coord(p, 0);
    cy = clip_coord(p, 1);
    cw = clip_coord(p, 3);
    projected++;
    if (cw < 6554) begin
      r.vis = 1'b0;
      r.sx = '0;
      r.sy = '0;
      offscreen++;
    end else begin
      nx = clamp32((cx * 65536) / cw);
      ny = clamp32((cy * 65536) / cw);
      hw = longint'(win_w / 2);
      hh = longint'(win_h / 2);
      r.vis = 1'b1;
      r.sx = 32'(clamp32(hw * nx + nx + hw * 65536));
      r.sy = 32'(clamp32(-(hh * ny) + ny + hh * 65536));
    end
    pending_points.push_back(r);
  endfunction

  function void check_result(logic vis, logic [31:0] sx, logic [31:0] sy);
    screen_point_t e;
    if (pending_points.size() == 0) begin
      $error("unexpected result on_screen=%0b x=%h y=%h", vis, sx, sy);
      errors++;
      return;
    end
    e = pending_points.pop_front();
    if (vis !== e.vis) begin
      $error("on_screen: expected %0b, got %0b", e.vis, vis);
      errors++;
    end
    if (sx !== e.sx) begin
      $error("screen_x: expected %h, got %h", e.sx, sx);
      errors++;
    end
    if (sy !== e.sy) begin
      $error("screen_y: expected %h, got %h", e.sy, sy);
      errors++;
    end
  endfunction
endclass

module tb_world_to_screen_projection_top;
  import wtsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = OP_LOAD;
  logic [3:0] entry_index = '0;
  logic signed [31:0] entry_value = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_WIDTH;
  logic [11:0] cfg_data = '0;
  logic result_valid;
  logic on_screen;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;

  projection_scoreboard sb;
  int req_count;
  bit calm;

  world_to_screen_projection_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .entry_index(entry_index), .entry_value(entry_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .on_screen(on_screen),
    .screen_x(screen_x), .screen_y(screen_y)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(on_screen, screen_x, screen_y);
  end

  function logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 262144)) - 131072);
      3: return 32'($signed($urandom_range(0, 8192)) - 4096);
      4: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Start stays high across back-to-back requests; it drops only while idling.
  task automatic send_request(logic o, logic [3:0] idx, logic [31:0] val,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (!calm && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    entry_index <= idx;
    entry_value <= val;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(o, idx, val, x, y, z);
    req_count++;
  endtask

  task automatic load_word(logic [3:0] idx, logic [31:0] val);
    send_request(OP_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_request(OP_PROJECT, 4'($urandom), $urandom, x, y, z);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_window(logic idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_window(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A perspective-like matrix so most points land on screen with w >= 0.1.
  task automatic load_camera();
    for (int i = 0; i < 16; i++) load_word(4'(i), 32'($signed($urandom_range(0, 131072)) - 65536));
    load_word(4'd15, 32'h0002_0000 + $urandom_range(0, 65536));
  endtask

  initial begin
    logic [11:0] sizes[6] = '{12'd0, 12'd4095, 12'd1, 12'd1024, 12'd1920, 12'd2};
    sb = new();
    sb.clear();
    req_count = 0;
    calm = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cleared matrix gives w = 0, then identity-like setups and extremes.
    project_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    load_word(4'd0, 32'h0001_0000);
    load_word(4'd5, 32'h0001_0000);
    load_word(4'd15, 32'h0001_0000);
    project_point(32'h0000_8000, 32'hffff_8000, 32'h0);
    project_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    load_word(4'd15, 32'd6554);
    project_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    load_word(4'd15, 32'd6553);
    project_point(32'h0, 32'h0, 32'h0);
    load_word(4'd11, 32'h8000_0000);
    project_point(32'h0, 32'h0, 32'h8000_0000);
    load_word(4'd11, 32'h7fff_ffff);
    project_point(32'h0, 32'h0, 32'h7fff_ffff);
    load_word(4'd12, 32'h7fff_ffff);
    load_word(4'd13, 32'h8000_0000);
    project_point(32'h0, 32'h0, 32'h0001_0000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_window(CFG_WIDTH, sizes[ph]);
      write_window(CFG_HEIGHT, sizes[5 - ph] ^ 12'($urandom_range(0, 1)));
      load_camera();
      calm = (ph == 2);
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 9) == 0) load_word(4'($urandom), pick_word());
        else project_point(pick_word(), pick_word(), pick_word());
      end
      drain();
    end

    $display("Ran %0d requests: %0d projections, %0d off screen, six window settings.",
             req_count, sb.projected, sb.offscreen);
    if (sb.errors == 0 && sb.pending_points.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
